/* sv/mfprl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mesh forward policy package
// Shared types, constants and register codes for the forwarding policy and
// flood rate limiter.
// ----------------------------------------------------------------------------
package mfprl_pkg;

    localparam int HASH_BITS   = 8;
    localparam int BLOCK_SLOTS = 8;
    localparam int HOP_CEILING = 64;

    localparam int NUM_BUCKETS = (1 << HASH_BITS) + 1;
    localparam int BUCKET_W    = HASH_BITS + 1;

    localparam int OUTQ_DEPTH  = 4;
    localparam int OUTQ_AW     = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CW     = OUTQ_AW + 1;

    localparam int PADDR_W     = 6;

    typedef enum logic [2:0] {
        REG_ENABLE        = 3'd0,
        REG_MAX_HOPS      = 3'd1,
        REG_BLOCKED_HASH  = 3'd2,
        REG_BLOCKED_COUNT = 3'd3,
        REG_DUTY_CEILING  = 3'd4,
        REG_FLOOD_LIMIT   = 3'd5,
        REG_WINDOW_MS     = 3'd6
    } reg_idx_t;

    typedef enum logic [2:0] {
        VERDICT_DISABLED = 3'd0,
        VERDICT_HOP      = 3'd1,
        VERDICT_BLOCKED  = 3'd2,
        VERDICT_BUDGET   = 3'd3,
        VERDICT_RATE     = 3'd4,
        VERDICT_FORWARD  = 3'd5
    } verdict_t;

    typedef struct packed {
        logic [7:0]  path_hash;
        logic        has_hash;
        logic        last_of_packet;
        logic [7:0]  hop_count;
        logic        is_flood;
        logic [31:0] now_ms;
        logic [15:0] used_permille;
    } in_item_t;

    typedef struct packed {
        logic        forward;
        logic [2:0]  verdict;
        logic [31:0] verdict_total;
    } out_item_t;

    typedef struct packed {
        logic        enable;
        logic [6:0]  max_hops;
        logic [63:0] blocked_hashes;
        logic [3:0]  blocked_count;
        logic [9:0]  duty_ceiling_permille;
        logic [15:0] flood_limit;
        logic [31:0] window_ms;
    } cfg_t;

    typedef struct packed {
        logic [31:0] start;
        logic [15:0] count;
    } bucket_t;

endpackage : mfprl_pkg
`default_nettype wire

/* sv/mfprl_regs.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mesh forward policy configuration registers
// APB-style register file holding the policy settings, with write clamping.
// ----------------------------------------------------------------------------
module mfprl_regs
    import mfprl_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [63:0]        pwdata,
    output logic      [63:0]        prdata,
    output logic                    pready,
    output cfg_t                    cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;
    logic [6:0] hops_wr;
    logic [3:0] count_wr;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[PADDR_W-1:3]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        hops_wr  = pwdata[6:0];
        count_wr = pwdata[3:0];
        if (hops_wr == 7'd0)
        begin
            hops_wr = 7'd1;
        end
        else if (hops_wr > 7'(HOP_CEILING))
        begin
            hops_wr = 7'(HOP_CEILING);
        end
        if (count_wr > 4'(BLOCK_SLOTS))
        begin
            count_wr = 4'(BLOCK_SLOTS);
        end

        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_ENABLE:        cfg_next.enable                = pwdata[0];
                REG_MAX_HOPS:      cfg_next.max_hops              = hops_wr;
                REG_BLOCKED_HASH:  cfg_next.blocked_hashes        = pwdata;
                REG_BLOCKED_COUNT: cfg_next.blocked_count         = count_wr;
                REG_DUTY_CEILING:  cfg_next.duty_ceiling_permille = pwdata[9:0];
                REG_FLOOD_LIMIT:   cfg_next.flood_limit           = pwdata[15:0];
                REG_WINDOW_MS:     cfg_next.window_ms             = pwdata[31:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable                <= 1'b0;
            cfg_reg.max_hops              <= (HOP_CEILING < 64) ? 7'(HOP_CEILING) : 7'd64;
            cfg_reg.blocked_hashes        <= '0;
            cfg_reg.blocked_count         <= '0;
            cfg_reg.duty_ceiling_permille <= '0;
            cfg_reg.flood_limit           <= '0;
            cfg_reg.window_ms             <= 32'd60000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_ENABLE:        prdata = {63'd0, cfg_reg.enable};
            REG_MAX_HOPS:      prdata = {57'd0, cfg_reg.max_hops};
            REG_BLOCKED_HASH:  prdata = cfg_reg.blocked_hashes;
            REG_BLOCKED_COUNT: prdata = {60'd0, cfg_reg.blocked_count};
            REG_DUTY_CEILING:  prdata = {54'd0, cfg_reg.duty_ceiling_permille};
            REG_FLOOD_LIMIT:   prdata = {48'd0, cfg_reg.flood_limit};
            REG_WINDOW_MS:     prdata = {32'd0, cfg_reg.window_ms};
            default:           prdata = 64'd0;
        endcase
    end

endmodule : mfprl_regs
`default_nettype wire

/* sv/mfprl_out_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mesh forward policy result queue
// Small FIFO that decouples the decision pipeline from the result receiver.
// ----------------------------------------------------------------------------
module mfprl_out_queue
    import mfprl_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire out_item_t          push_data,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output out_item_t               result,
    output logic      [OUTQ_CW-1:0] count
);

    out_item_t            slot_reg [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0]   wr_ptr_reg;
    logic [OUTQ_AW-1:0]   rd_ptr_reg;
    logic [OUTQ_CW-1:0]   count_reg;
    logic                 pop;

    assign result_valid = (count_reg != '0);
    assign result       = slot_reg[rd_ptr_reg];
    assign pop          = result_valid && !result_stall;
    assign count        = count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule : mfprl_out_queue
`default_nettype wire

/* sv/mesh_forward_policy_rate_limiter.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mesh forward policy rate limiter
// Forwarding decision for a mesh repeater with a per-neighbour flood limit.
// ----------------------------------------------------------------------------
// Each input transaction carries one path hash of a packet; the transaction
// flagged last_of_packet triggers the decision and yields exactly one result
// transaction, while other transactions yield none. Both channels use valid
// and stall. Configuration is written through the APB-style port; the user
// must do so only while the block is idle, as the block does not enforce it.
// The block accepts one transaction per cycle unless it stalls the input.
// From acceptance to the result queue, stage 0 checks the hop limit,
// blocked hashes and airtime ceiling and reads the neighbour's window entry
// from the bucket memory, stage 1 applies the flood window and writes the
// entry back (with forwarding to a read of the same bucket in that cycle),
// and stage 2 bumps the verdict counter. The result is then offered from a
// four-entry queue.
// When the receiver stalls, results wait in the queue; input is stalled only
// once queued and in-flight decisions would fill it.
// Reset restores the default settings and clears the per-packet state, the
// verdict counters and every bucket valid bit, so the block is ready at once.
// ----------------------------------------------------------------------------
module mesh_forward_policy_rate_limiter
    import mfprl_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire in_item_t           item,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output out_item_t               result,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [63:0]        pwdata,
    output logic      [63:0]        prdata,
    output logic                    pready
);

    localparam logic [BUCKET_W-1:0] DIRECT_BUCKET = BUCKET_W'(1 << HASH_BITS);

    cfg_t cfg;

    mfprl_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ------------------------------------------------------------------
    // Stage 0: per-packet path state and the early checks.
    // ------------------------------------------------------------------
    logic                  accept;
    logic                  decide;
    logic [HASH_BITS-1:0]  hash_in;
    logic                  hash_hit;
    logic                  seen_blocked_reg;
    logic                  seen_blocked_next;
    logic [HASH_BITS-1:0]  last_hash_reg;
    logic [HASH_BITS-1:0]  last_hash_next;
    logic                  any_hash_reg;
    logic                  any_hash_next;
    logic [BUCKET_W-1:0]   rd_addr;
    verdict_t              pre_verdict;
    logic                  rate_needed;

    assign accept  = item_valid && !item_stall;
    assign decide  = accept && item.last_of_packet;
    assign hash_in = item.path_hash[HASH_BITS-1:0];

    always_comb
    begin
        hash_hit = 1'b0;
        for (int i = 0; i < BLOCK_SLOTS; i++)
        begin
            if ((4'(i) < cfg.blocked_count)
                && (cfg.blocked_hashes[8*i +: HASH_BITS] == hash_in))
            begin
                hash_hit = 1'b1;
            end
        end
    end

    assign seen_blocked_next = seen_blocked_reg || (item.has_hash && hash_hit);
    assign last_hash_next    = item.has_hash ? hash_in : last_hash_reg;
    assign any_hash_next     = any_hash_reg || item.has_hash;
    assign rd_addr           = any_hash_next ? {1'b0, last_hash_next} : DIRECT_BUCKET;

    // The checks ahead of the flood window are settled before the bucket
    // entry is available.
    always_comb
    begin
        rate_needed = 1'b0;
        priority if (!cfg.enable)
        begin
            pre_verdict = VERDICT_DISABLED;
        end
        else if (item.hop_count >= {1'b0, cfg.max_hops})
        begin
            pre_verdict = VERDICT_HOP;
        end
        else if (seen_blocked_next)
        begin
            pre_verdict = VERDICT_BLOCKED;
        end
        else if ((cfg.duty_ceiling_permille != '0)
                 && (item.used_permille >= {6'd0, cfg.duty_ceiling_permille}))
        begin
            pre_verdict = VERDICT_BUDGET;
        end
        else
        begin
            pre_verdict = VERDICT_FORWARD;
            rate_needed = item.is_flood && (cfg.flood_limit != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_blocked_reg <= 1'b0;
            last_hash_reg    <= '0;
            any_hash_reg     <= 1'b0;
        end
        else if (accept)
        begin
            if (item.last_of_packet)
            begin
                seen_blocked_reg <= 1'b0;
                last_hash_reg    <= '0;
                any_hash_reg     <= 1'b0;
            end
            else
            begin
                seen_blocked_reg <= seen_blocked_next;
                last_hash_reg    <= last_hash_next;
                any_hash_reg     <= any_hash_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Bucket memory: one window entry per neighbour plus the direct bucket.
    // An entry whose valid bit is clear reads as an empty window at time 0.
    // ------------------------------------------------------------------
    bucket_t               bucket_mem [NUM_BUCKETS];
    logic [NUM_BUCKETS-1:0] bucket_vld_reg;
    bucket_t               rd_data_reg;
    logic                  rd_vld_reg;
    logic                  fwd_hit_reg;
    bucket_t               fwd_data_reg;
    logic                  wr_en;
    bucket_t               wr_data;

    logic                  s1_valid_reg;
    logic [BUCKET_W-1:0]   s1_bucket_reg;
    logic [31:0]           s1_now_reg;
    verdict_t              s1_pre_reg;
    logic                  s1_rate_reg;

    always_ff @(posedge clk)
    begin
        rd_data_reg  <= bucket_mem[rd_addr];
        fwd_data_reg <= wr_data;
        if (wr_en)
        begin
            bucket_mem[s1_bucket_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bucket_vld_reg <= '0;
            rd_vld_reg     <= 1'b0;
            fwd_hit_reg    <= 1'b0;
        end
        else
        begin
            rd_vld_reg  <= bucket_vld_reg[rd_addr];
            // A write-back in the same cycle as a read of the same entry
            // would otherwise return the stale contents.
            fwd_hit_reg <= wr_en && (s1_bucket_reg == rd_addr);
            if (wr_en)
            begin
                bucket_vld_reg[s1_bucket_reg] <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: fixed-window check and write-back.
    // ------------------------------------------------------------------
    bucket_t     cur;
    logic [31:0] elapsed;
    logic        expired;
    logic [31:0] start_eff;
    logic [15:0] count_eff;
    logic        limited;
    verdict_t    s1_verdict;

    always_comb
    begin
        if (fwd_hit_reg)
        begin
            cur = fwd_data_reg;
        end
        else if (rd_vld_reg)
        begin
            cur = rd_data_reg;
        end
        else
        begin
            cur = '0;
        end
        elapsed   = s1_now_reg - cur.start;
        expired   = (s1_now_reg < cur.start) || (elapsed >= cfg.window_ms);
        start_eff = expired ? s1_now_reg : cur.start;
        count_eff = expired ? 16'd0 : cur.count;
        limited   = (count_eff >= cfg.flood_limit);

        wr_data.start = start_eff;
        wr_data.count = limited ? count_eff : count_eff + 16'd1;
        wr_en         = s1_valid_reg && s1_rate_reg;

        if (s1_rate_reg && limited)
        begin
            s1_verdict = VERDICT_RATE;
        end
        else
        begin
            s1_verdict = s1_pre_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: verdict counters.
    // ------------------------------------------------------------------
    logic        s2_valid_reg;
    verdict_t    s2_verdict_reg;
    logic [31:0] cnt_reg [5];
    logic [2:0]  cnt_idx;
    logic [31:0] cnt_next;
    logic        counted;
    out_item_t   push_data;

    assign counted  = (s2_verdict_reg != VERDICT_DISABLED);
    assign cnt_idx  = 3'(s2_verdict_reg) - 3'd1;
    assign cnt_next = cnt_reg[cnt_idx] + 32'd1;

    assign push_data.forward       = (s2_verdict_reg == VERDICT_FORWARD);
    assign push_data.verdict       = 3'(s2_verdict_reg);
    assign push_data.verdict_total = counted ? cnt_next : 32'd0;

    always_ff @(posedge clk)
    begin
        if (decide)
        begin
            s1_bucket_reg <= rd_addr;
            s1_now_reg    <= item.now_ms;
            s1_pre_reg    <= pre_verdict;
            s1_rate_reg   <= rate_needed;
        end
        if (s1_valid_reg)
        begin
            s2_verdict_reg <= s1_verdict;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            for (int i = 0; i < 5; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            s1_valid_reg <= decide;
            s2_valid_reg <= s1_valid_reg;
            if (s2_valid_reg && counted)
            begin
                cnt_reg[cnt_idx] <= cnt_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result queue and input flow control.
    // ------------------------------------------------------------------
    logic [OUTQ_CW-1:0] q_count;
    logic [OUTQ_CW:0]   committed;

    mfprl_out_queue u_out_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (s2_valid_reg),
        .push_data    (push_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .count        (q_count)
    );

    // Every decision in flight is guaranteed a queue slot.
    assign committed  = {1'b0, q_count} + (OUTQ_CW+1)'(s1_valid_reg)
                        + (OUTQ_CW+1)'(s2_valid_reg);
    assign item_stall = (committed >= (OUTQ_CW+1)'(OUTQ_DEPTH));

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (q_count < OUTQ_CW'(OUTQ_DEPTH)))
        else $error("result queue overflow");

    a_forward_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && (s1_bucket_reg == rd_addr)) |=> fwd_hit_reg)
        else $error("bucket write-back not forwarded");

    a_forward_flag: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.forward == (result.verdict == VERDICT_FORWARD)))
        else $error("forward flag disagrees with verdict");

    a_disabled_total: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.verdict == VERDICT_DISABLED))
        |-> (result.verdict_total == 32'd0))
        else $error("disabled verdict carries a count");

endmodule : mesh_forward_policy_rate_limiter
`default_nettype wire

/* test/mesh_forward_policy_rate_limiter_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mesh forward policy rate limiter testbench
// Streams packets of path-hash transactions into the forwarding policy. A
// behavioural copy of the policy predicts every verdict, and each result
// transaction is checked against it while both channels idle and stall.
// ----------------------------------------------------------------------------
module mesh_forward_policy_rate_limiter_tb;
    import mfprl_pkg::*;

    localparam int HALF_PERIOD     = 5;
    localparam int RESET_CYCLES    = 4;
    // The decision pipeline plus the result queue is well under this depth.
    localparam int DRAIN_CYCLES    = 12;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int LONG_HOLD       = 300;
    localparam int REG_STRIDE      = 8;
    // One past the last register; writes to it must leave the settings alone.
    localparam int SPARE_REG_INDEX = 7;
    localparam int DIRECT_BUCKET   = 1 << HASH_BITS;
    localparam int PHASE_ITEMS     = 170;

    logic               clk;
    logic               rst_n;
    logic               item_valid;
    logic               item_stall;
    in_item_t           item;
    logic               result_valid;
    logic               result_stall;
    out_item_t          result;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [63:0]        pwdata;
    logic [63:0]        prdata;
    logic               pready;

    mesh_forward_policy_rate_limiter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        clk = 1'b0;
        #HALF_PERIOD;
        clk = 1'b1;
        #HALF_PERIOD;
    end

    // ------------------------------------------------------------------------
    // Shadow of the policy: settings, per-packet state, bucket windows and
    // verdict tallies, all kept at the widths that the block uses.
    // ------------------------------------------------------------------------
    cfg_t        shadow_cfg;
    logic        pkt_blocked;
    logic [7:0]  pkt_last_hash;
    logic        pkt_any_hash;
    logic [31:0] win_start [NUM_BUCKETS];
    logic [15:0] win_count [NUM_BUCKETS];
    logic [31:0] verdict_tally [5];

    // Verdicts still owed by the block, oldest first.
    out_item_t   pending_verdicts [$];
    int          errors;
    int          items_sent;

    // Traffic shaping shared by the sender and the result sink.
    bit          gaps_on;
    int          hold_request;
    logic [31:0] clock_ms;
    int unsigned time_step_max;

    // True when the hash matches one of the valid blocked slots.
    function automatic bit hash_listed(input logic [HASH_BITS-1:0] h);
        for (int i = 0; i < BLOCK_SLOTS && i < int'(shadow_cfg.blocked_count); i++)
        begin
            if (shadow_cfg.blocked_hashes[8*i +: HASH_BITS] == h)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Fixed-window flood limit for one bucket. The window restarts when it
    // has run out or when time has gone backwards.
    function automatic bit flood_window_ok(input int bucket, input logic [31:0] now);
        logic [31:0] elapsed;
        if (shadow_cfg.flood_limit == 0)
            return 1'b1;
        elapsed = now - win_start[bucket];
        if (now < win_start[bucket] || elapsed >= shadow_cfg.window_ms)
        begin
            win_start[bucket] = now;
            win_count[bucket] = '0;
        end
        if (win_count[bucket] >= shadow_cfg.flood_limit)
            return 1'b0;
        win_count[bucket] = win_count[bucket] + 16'd1;
        return 1'b1;
    endfunction

    // Folds one accepted transaction into the shadow state. Returns 1 and the
    // expected verdict when the transaction closes a packet.
    function automatic bit decide_packet(input in_item_t it, output out_item_t verdict_out);
        logic [HASH_BITS-1:0] h;
        verdict_t             v;
        int                   bucket;
        h = it.path_hash[HASH_BITS-1:0];
        verdict_out = '0;
        if (it.has_hash)
        begin
            if (hash_listed(h))
                pkt_blocked = 1'b1;
            pkt_last_hash = 8'(h);
            pkt_any_hash  = 1'b1;
        end
        if (!it.last_of_packet)
            return 1'b0;

        // An empty path falls into the direct bucket after the hash buckets.
        bucket = pkt_any_hash ? int'(pkt_last_hash) : DIRECT_BUCKET;
        if (!shadow_cfg.enable)
            v = VERDICT_DISABLED;
        else if (it.hop_count >= shadow_cfg.max_hops)
            v = VERDICT_HOP;
        else if (pkt_blocked)
            v = VERDICT_BLOCKED;
        else if (shadow_cfg.duty_ceiling_permille != 0 &&
                 it.used_permille >= shadow_cfg.duty_ceiling_permille)
            v = VERDICT_BUDGET;
        else if (it.is_flood && !flood_window_ok(bucket, it.now_ms))
            v = VERDICT_RATE;
        else
            v = VERDICT_FORWARD;

        verdict_out.forward = (v == VERDICT_FORWARD);
        verdict_out.verdict = v;
        // A disabled block counts nothing and reports a zero total.
        if (v != VERDICT_DISABLED)
        begin
            verdict_tally[int'(v) - 1] = verdict_tally[int'(v) - 1] + 32'd1;
            verdict_out.verdict_total  = verdict_tally[int'(v) - 1];
        end

        pkt_blocked   = 1'b0;
        pkt_last_hash = '0;
        pkt_any_hash  = 1'b0;
        return 1'b1;
    endfunction

    // Idle gap length: mostly none, often short, now and then long.
    function automatic int pick_gap();
        int r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Hashes lean towards the blocked slots and a handful of busy neighbours,
    // so that blocking and flood windows are both exercised.
    function automatic logic [7:0] pick_hash();
        int r;
        int slot;
        r    = $urandom_range(0, 9);
        slot = $urandom_range(0, BLOCK_SLOTS - 1);
        if (r < 1)
            return shadow_cfg.blocked_hashes[8*slot +: 8];
        if (r < 6)
            return 8'($urandom_range(0, 7));
        return 8'($urandom_range(0, 255));
    endfunction

    // A transaction with every field random.
    function automatic in_item_t noise_item();
        in_item_t it;
        it.path_hash      = 8'($urandom_range(0, 255));
        it.has_hash       = 1'($urandom_range(0, 1));
        it.last_of_packet = 1'($urandom_range(0, 1));
        it.hop_count      = 8'($urandom_range(0, 255));
        it.is_flood       = 1'($urandom_range(0, 1));
        it.now_ms         = $urandom();
        it.used_permille  = 16'($urandom_range(0, 65535));
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Sender. Valid is left high after a transaction is accepted, so that a
    // back-to-back transaction never lowers and raises it in one time step;
    // it is lowered only when a gap follows or the stimulus pauses.
    // ------------------------------------------------------------------------
    task automatic send_item(input in_item_t it);
        int        gap;
        out_item_t verdict_out;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (item_stall);
        items_sent++;
        if (decide_packet(it, verdict_out))
            pending_verdicts.push_back(verdict_out);
    endtask

    // One packet: path_len hashed transactions, the last of them carrying
    // tail_hash, optionally followed by a bare closing transaction. An empty
    // path is a single bare closing transaction. A negative lead_hash picks
    // the earlier hashes at random.
    task automatic send_packet(input int path_len, input int lead_hash,
                               input logic [7:0] tail_hash, input bit bare_end,
                               input logic [7:0] hops, input bit flood,
                               input logic [31:0] now, input logic [15:0] used);
        in_item_t it;
        int       n;
        n = (path_len == 0) ? 1 : path_len + int'(bare_end);
        for (int i = 0; i < n; i++)
        begin
            it = noise_item();
            it.has_hash       = (i < path_len);
            it.last_of_packet = (i == n - 1);
            if (i == path_len - 1)
                it.path_hash = tail_hash;
            else if (i < path_len)
                it.path_hash = (lead_hash < 0) ? pick_hash() : 8'(lead_hash);
            if (i == n - 1)
            begin
                it.hop_count     = hops;
                it.is_flood      = flood;
                it.now_ms        = now;
                it.used_permille = used;
            end
            send_item(it);
        end
    endtask

    // Mostly well-formed packets on a clock that usually runs forwards, with
    // some stray transactions and the odd step back or jump in time.
    task automatic send_random_packet();
        int          r;
        int          len;
        logic [7:0]  hops;
        logic [15:0] used;
        r = $urandom_range(0, 99);
        if (r < 5)
            clock_ms = clock_ms - $urandom_range(1, time_step_max);
        else if (r < 8)
            clock_ms = $urandom();
        else
            clock_ms = clock_ms + $urandom_range(0, time_step_max);

        if ($urandom_range(0, 99) < 15)
        begin
            send_item(noise_item());
            return;
        end
        len  = ($urandom_range(0, 9) < 2) ? 0 : $urandom_range(1, 4);
        hops = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, shadow_cfg.max_hops));
        used = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                           : 16'($urandom_range(0, 1023));
        send_packet(len, -1, pick_hash(), $urandom_range(0, 4) == 0, hops,
                    $urandom_range(0, 9) < 7, clock_ms, used);
    endtask

    // Stops offering and waits until every owed verdict is in, then lets the
    // pipeline run dry so that transactions without a result are finished.
    task automatic settle();
        item_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // APB write: a setup cycle, then an access cycle at whose closing edge
    // the register takes the value. The shadow mirrors the clamping rules.
    task automatic write_reg(input int idx, input logic [63:0] value);
        logic [6:0] hops;
        logic [3:0] slots;
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx * REG_STRIDE);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_ENABLE:
                shadow_cfg.enable = value[0];
            REG_MAX_HOPS:
            begin
                hops = value[6:0];
                if (hops < 7'd1)
                    hops = 7'd1;
                if (hops > 7'(HOP_CEILING))
                    hops = 7'(HOP_CEILING);
                shadow_cfg.max_hops = hops;
            end
            REG_BLOCKED_HASH:
                shadow_cfg.blocked_hashes = value;
            REG_BLOCKED_COUNT:
            begin
                slots = value[3:0];
                if (slots > 4'(BLOCK_SLOTS))
                    slots = 4'(BLOCK_SLOTS);
                shadow_cfg.blocked_count = slots;
            end
            REG_DUTY_CEILING:
                shadow_cfg.duty_ceiling_permille = value[9:0];
            REG_FLOOD_LIMIT:
                shadow_cfg.flood_limit = value[15:0];
            REG_WINDOW_MS:
                shadow_cfg.window_ms = value[31:0];
            default:
                ;
        endcase
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic [63:0] en, input logic [63:0] hops,
                                  input logic [63:0] blocked, input logic [63:0] slots,
                                  input logic [63:0] duty, input logic [63:0] limit,
                                  input logic [63:0] window);
        write_reg(REG_ENABLE, en);
        write_reg(REG_MAX_HOPS, hops);
        write_reg(REG_BLOCKED_HASH, blocked);
        write_reg(REG_BLOCKED_COUNT, slots);
        write_reg(REG_DUTY_CEILING, duty);
        write_reg(REG_FLOOD_LIMIT, limit);
        write_reg(REG_WINDOW_MS, window);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Out of reset forwarding is off: every packet is refused with a zero
    // total, and nothing is counted or charged to a bucket.
    task automatic test_disabled_after_reset();
        send_packet(0, -1, 8'h00, 1'b0, 8'd0, 1'b1, 32'd0, 16'd0);
        send_packet(2, 8'h10, 8'h10, 1'b0, 8'd255, 1'b1, 32'hFFFF_FFFF, 16'hFFFF);
        send_packet(1, -1, 8'h10, 1'b1, 8'd0, 1'b1, 32'd5, 16'd0);
    endtask

    // Walks through each verdict in priority order, the flood window running
    // out, time going backwards, the direct bucket and a bare closing
    // transaction that inherits the path state.
    task automatic test_verdict_order();
        // Blocked slots from low byte up: 3C C3 AA 55 01 7F 80 FF. A hop
        // limit of 127 clamps to the ceiling and a slot count of 15 to 8.
        apply_settings(64'd1, 64'd127, 64'hFF80_7F01_55AA_C33C, 64'd15, 64'd1000,
                       64'd2, 64'd100);
        send_packet(1, -1, 8'h10, 1'b0, 8'd63, 1'b1, 32'd1000, 16'd999);
        send_packet(1, -1, 8'h10, 1'b0, 8'd64, 1'b1, 32'd1010, 16'd0);
        send_packet(1, -1, 8'h10, 1'b0, 8'd255, 1'b1, 32'd1010, 16'd0);
        send_packet(2, 8'h3C, 8'h10, 1'b0, 8'd0, 1'b1, 32'd1010, 16'd0);
        send_packet(2, 8'h10, 8'hFF, 1'b0, 8'd0, 1'b1, 32'd1010, 16'd0);
        send_packet(1, -1, 8'h10, 1'b0, 8'd0, 1'b1, 32'd1010, 16'd1000);
        send_packet(1, -1, 8'h10, 1'b0, 8'd0, 1'b1, 32'd1010, 16'hFFFF);
        // Second flood packet of the window passes, the third is limited,
        // and a packet that is not a flood is never limited.
        send_packet(1, -1, 8'h10, 1'b0, 8'd0, 1'b1, 32'd1050, 16'd0);
        send_packet(1, -1, 8'h10, 1'b0, 8'd0, 1'b1, 32'd1060, 16'd0);
        send_packet(1, -1, 8'h10, 1'b0, 8'd0, 1'b0, 32'd1070, 16'd0);
        send_packet(1, -1, 8'h10, 1'b0, 8'd0, 1'b1, 32'd1100, 16'd0);
        send_packet(1, -1, 8'h10, 1'b0, 8'd0, 1'b1, 32'd500, 16'd0);
        repeat (3) send_packet(0, -1, 8'h00, 1'b0, 8'd0, 1'b1, 32'd0, 16'd0);
        send_packet(1, -1, 8'h3C, 1'b1, 8'd0, 1'b1, 32'd0, 16'd0);
    endtask

    // Register clamping and the settings that switch checks off: a hop
    // limit of zero clamps to one, a zero slot count, zero ceiling and zero
    // window, then an unlimited flood count and the widest ceiling.
    task automatic test_register_limits();
        apply_settings(64'd1, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 64'd0, 64'd1, 64'd0);
        write_reg(SPARE_REG_INDEX, {$urandom(), $urandom()});
        repeat (2) send_packet(1, -1, 8'hFF, 1'b0, 8'd0, 1'b1, 32'hFFFF_FFFF, 16'hFFFF);
        send_packet(1, -1, 8'hFF, 1'b0, 8'd1, 1'b1, 32'd0, 16'd0);
        write_reg(REG_FLOOD_LIMIT, 64'd0);
        write_reg(REG_WINDOW_MS, 64'hFFFF_FFFF);
        write_reg(REG_DUTY_CEILING, 64'd1023);
        write_reg(REG_BLOCKED_COUNT, 64'd1);
        send_packet(1, -1, 8'h00, 1'b0, 8'd0, 1'b1, 32'd7, 16'd1022);
        send_packet(1, -1, 8'h00, 1'b0, 8'd0, 1'b1, 32'd7, 16'd1023);
        send_packet(1, -1, 8'hFF, 1'b0, 8'd0, 1'b1, 32'd7, 16'd0);
    endtask

    // Random traffic under a run of settings, the extremes among them. The
    // third phase runs with no idling on either side.
    task automatic test_random_settings();
        int target;
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0:
                begin
                    apply_settings(64'd1, 64'd64, {$urandom(), $urandom()}, 64'd2, 64'd0,
                                   64'd3, 64'd500);
                    time_step_max = 200;
                end
                1:
                begin
                    apply_settings(64'd1, 64'd20, {$urandom(), $urandom()}, 64'd8, 64'd900,
                                   64'd1, 64'd50);
                    time_step_max = 30;
                end
                2:
                begin
                    apply_settings(64'd1, 64'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 64'd1000,
                                   64'd65535, 64'hFFFF_FFFF);
                    time_step_max = 100000;
                end
                3:
                begin
                    apply_settings(64'd1, 64'd40, {$urandom(), $urandom()}, 64'd15, 64'd700,
                                   64'd2, 64'd1);
                    time_step_max = 2;
                end
                4:
                begin
                    apply_settings(64'd1, 64'd64, {$urandom(), $urandom()}, 64'd4, 64'd0,
                                   64'd4, 64'd0);
                    time_step_max = 50;
                end
                default:
                begin
                    // Only bit 0 of the enable register counts, so this
                    // switches forwarding off.
                    apply_settings(64'hFFFF_FFFF_FFFF_FFFE, 64'd1, {$urandom(), $urandom()},
                                   64'd3, 64'd1, 64'd1, 64'd10);
                    time_step_max = 10;
                end
            endcase
            gaps_on = (p != 2);
            target  = items_sent + PHASE_ITEMS;
            while (items_sent < target)
                send_random_packet();
        end
    endtask

    // The result sink holds off for a long stretch while the sender keeps
    // offering back to back, so the result queue fills and the input stalls.
    // Then the sender pauses until every verdict is in before carrying on.
    task automatic test_backpressure();
        apply_settings(64'd1, 64'd64, {$urandom(), $urandom()}, 64'd2, 64'd0, 64'd3,
                       64'd1000);
        gaps_on       = 1'b0;
        time_step_max = 200;
        hold_request  = LONG_HOLD;
        repeat (60)
        begin
            clock_ms = clock_ms + 32'd7;
            send_packet(1, -1, pick_hash(), 1'b0, 8'd0, 1'b1, clock_ms, 16'd0);
        end
        settle();
        gaps_on = 1'b1;
        repeat (120) send_random_packet();
    endtask

    // ------------------------------------------------------------------------
    // Result sink: random stalls of the same shape as the sender's gaps, or
    // one long hold-off when a test asks for it, counted here in cycles.
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int stall_left;
        stall_left   = 0;
        result_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            else if (stall_left == 0 && gaps_on && $urandom_range(0, 99) < 25)
                stall_left = pick_gap();
            if (stall_left > 0)
            begin
                result_stall <= 1'b1;
                stall_left--;
            end
            else
                result_stall <= 1'b0;
        end
    end

    // Every accepted result transaction is matched with the oldest owed
    // verdict, field by field.
    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $error("result transaction with no verdict owed: verdict %0d total %0d",
                       result.verdict, result.verdict_total);
                errors++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (result.forward !== want.forward)
                begin
                    $error("forward: expected %0d, got %0d", want.forward, result.forward);
                    errors++;
                end
                if (result.verdict !== want.verdict)
                begin
                    $error("verdict: expected %0d, got %0d", want.verdict, result.verdict);
                    errors++;
                end
                if (result.verdict_total !== want.verdict_total)
                begin
                    $error("verdict_total: expected %0d, got %0d",
                           want.verdict_total, result.verdict_total);
                    errors++;
                end
            end
        end
    end

    // Ends the run when neither channel has moved a transaction for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : stimulus
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        errors        = 0;
        items_sent    = 0;
        gaps_on       = 1'b1;
        hold_request  = 0;
        clock_ms      = 32'd0;
        time_step_max = 100;

        // Shadow starts from the reset settings and empty state.
        shadow_cfg                       = '0;
        shadow_cfg.max_hops              = 7'd64;
        shadow_cfg.window_ms             = 32'd60000;
        pkt_blocked                      = 1'b0;
        pkt_last_hash                    = '0;
        pkt_any_hash                     = 1'b0;
        for (int b = 0; b < NUM_BUCKETS; b++)
        begin
            win_start[b] = '0;
            win_count[b] = '0;
        end
        for (int v = 0; v < 5; v++)
            verdict_tally[v] = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_disabled_after_reset();
        test_verdict_order();
        test_register_limits();
        test_random_settings();
        test_backpressure();

        settle();
        if (errors == 0 && pending_verdicts.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
